// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file of the pending queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds on every clock edge outside reset.
`define CHK_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define CHK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pipq_pkg.sv =====
// Shared types, codes and defaults of the priority interrupt pending queue.
package pipq_pkg;

    localparam int NUM_LINES_DEF     = 16;
    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int PRIORITY_BITS_DEF = 4;
    localparam int RESULT_LIMIT      = 16;

    localparam int LINE_W    = 4;
    localparam int ACTION_W  = 2;
    localparam int MASK_W    = 16;
    localparam int PTAB_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;

    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RAISE    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DISP_ONE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_DISP_ALL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_TAB  = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [LINE_W-1:0]   irq;
    } t_item;

    typedef struct packed {
        logic              dispatched;
        logic [LINE_W-1:0] dispatched_line;
        logic              dropped;
        logic              last;
    } t_result;

endpackage

// ===== design/pipq_mem.sv =====
// Pending-line storage: one write port, one read port with registered data.
module pipq_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 4,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pipq_pick.sv =====
// Single compare unit: tracks the best eligible entry seen during one scan.
module pipq_pick
    import pipq_pkg::*;
#(
    parameter int NUM_LINES     = NUM_LINES_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
    parameter int DEPTH         = QUEUE_DEPTH_DEF,
    localparam int AW           = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_init,
    input  logic              i_valid,
    input  logic [LINE_W-1:0] i_line,
    input  logic [AW-1:0]     i_pos,
    input  logic              i_global_en,
    input  logic [MASK_W-1:0] i_line_mask,
    input  logic [PTAB_W-1:0] i_prio_table,
    output logic              o_found,
    output logic [AW-1:0]     o_pos,
    output logic [LINE_W-1:0] o_line
);

    logic                     r_found;
    logic [AW-1:0]            r_pos;
    logic [LINE_W-1:0]        r_line;
    logic [PRIORITY_BITS-1:0] r_pri;

    logic [3:0]               nibble;
    logic [PRIORITY_BITS-1:0] cand_pri;
    logic                     eligible;
    logic                     better;

    always_comb begin
        nibble   = i_prio_table[i_line * 4 +: 4];
        cand_pri = nibble[PRIORITY_BITS-1:0];
        eligible = i_global_en && ({1'b0, i_line} < 5'(NUM_LINES)) && i_line_mask[i_line];
        // strict less-than keeps the earliest arrival on a tie
        better   = eligible && (!r_found || (cand_pri < r_pri));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_init) begin
            r_found <= 1'b0;
        end else if (i_valid && better) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && better) begin
            r_pos  <= i_pos;
            r_line <= i_line;
            r_pri  <= cand_pri;
        end
    end

    assign o_found = r_found;
    assign o_pos   = r_pos;
    assign o_line  = r_line;

endmodule

// ===== design/priority_interrupt_pending_queue.sv =====
// Top level of the priority interrupt pending queue: sequencer, registers and checks.
//
// Raised interrupt lines are queued in order of arrival, duplicates allowed, in a
// RAM of QUEUE_DEPTH entries with one write port and one read port. A transaction is
// taken when start is high and busy is low. Clear and raise finish in the accepting
// cycle: busy stays low and the single result appears on the next cycle. A dispatch
// runs a small sequencer around one compare unit: a scan reads every queued entry
// through the RAM read port, one per cycle, keeping the eligible entry with the lowest
// priority (earliest arrival on a tie); a decide cycle follows, then the entries behind
// the winner are moved down one place, one per cycle. Dispatch-all repeats this for
// up to 16 entries. Each result is held on o_result for exactly one cycle under
// o_result_strobe, and the receiver must take it then: there is no back-pressure.
// Results of a dispatch-all appear one per dispatched entry, the final one marked
// last; busy falls in the cycle that shows the last result. Configuration writes are
// always accepted and must only be issued while the block is idle. The RAM needs no
// clearing after reset: only entries below the fill count are ever read.
module priority_interrupt_pending_queue
    import pipq_pkg::*;
#(
    parameter int NUM_LINES     = NUM_LINES_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    output logic                 o_result_strobe,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    `include "assert_macros.svh"

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = $clog2(RESULT_LIMIT + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_REMOVE = 2'd3;

    // configuration registers
    logic              r_global_en;
    logic [MASK_W-1:0] r_line_mask;
    logic [PTAB_W-1:0] r_prio_table;

    // sequencer state
    logic [1:0]        r_state,     n_state;
    logic [CW-1:0]     r_count,     n_count;
    logic [CW-1:0]     r_idx,       n_idx;
    logic              r_all,       n_all;
    logic [NW-1:0]     r_nres,      n_nres;
    logic              r_have_hold, n_have_hold;
    logic [LINE_W-1:0] r_hold_line, n_hold_line;
    logic              r_rd_vld;
    logic [CW-1:0]     r_rd_pos;
    logic              r_strobe,    n_strobe;
    t_result           r_res,       n_res;

    logic              accept;
    logic              issue;
    logic              raise_we;
    logic              rm_we;
    logic [AW-1:0]     rm_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [LINE_W-1:0] mem_wdata;
    logic [LINE_W-1:0] mem_rdata;

    logic              pick_init;
    logic              pick_found;
    logic [AW-1:0]     pick_pos;
    logic [LINE_W-1:0] pick_line;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // one RAM read per cycle while the scan or the close-up still has entries to visit
    assign issue = ((r_state == S_SCAN) || (r_state == S_REMOVE)) && (r_idx < r_count);

    // close-up: each entry read at position k is written back at k - 1
    assign rm_we     = (r_state == S_REMOVE) && r_rd_vld;
    assign rm_addr   = AW'(r_rd_pos - CW'(1));
    assign mem_we    = raise_we || rm_we;
    assign mem_waddr = raise_we ? r_count[AW-1:0] : rm_addr;
    assign mem_wdata = raise_we ? i_item.irq : mem_rdata;

    pipq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (LINE_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    pipq_pick #(
        .NUM_LINES     (NUM_LINES),
        .PRIORITY_BITS (PRIORITY_BITS),
        .DEPTH         (QUEUE_DEPTH)
    ) u_pick (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_init       (pick_init),
        .i_valid      ((r_state == S_SCAN) && r_rd_vld),
        .i_line       (mem_rdata),
        .i_pos        (r_rd_pos[AW-1:0]),
        .i_global_en  (r_global_en),
        .i_line_mask  (r_line_mask),
        .i_prio_table (r_prio_table),
        .o_found      (pick_found),
        .o_pos        (pick_pos),
        .o_line       (pick_line)
    );

    // Sequencer. A found entry is held back until the next scan, or the end of its
    // close-up, shows whether another follows, so that last is marked on the right result.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_all       = r_all;
        n_nres      = r_nres;
        n_have_hold = r_have_hold;
        n_hold_line = r_hold_line;
        n_strobe    = 1'b0;
        n_res       = r_res;
        pick_init   = 1'b0;
        raise_we    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res.dispatched      = 1'b0;
                    n_res.dispatched_line = '0;
                    n_res.dropped         = 1'b0;
                    n_res.last            = 1'b1;
                    unique case (i_item.action) inside
                        ACT_CLEAR: begin
                            n_count  = '0;
                            n_strobe = 1'b1;
                        end
                        ACT_RAISE: begin
                            n_strobe = 1'b1;
                            // lines beyond the implemented set are ignored silently
                            if ({1'b0, i_item.irq} < 5'(NUM_LINES)) begin
                                if (r_count >= CW'(QUEUE_DEPTH)) begin
                                    n_res.dropped = 1'b1;
                                end else begin
                                    raise_we = 1'b1;
                                    n_count  = r_count + CW'(1);
                                end
                            end
                        end
                        ACT_DISP_ONE, ACT_DISP_ALL: begin
                            n_state     = S_SCAN;
                            n_idx       = '0;
                            n_all       = (i_item.action == ACT_DISP_ALL);
                            n_nres      = '0;
                            n_have_hold = 1'b0;
                            pick_init   = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // advance the read pointer; the last read lands in this cycle
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (pick_found) begin
                    // release the previously held entry, not the final one
                    if (r_have_hold) begin
                        n_strobe              = 1'b1;
                        n_res.dispatched      = 1'b1;
                        n_res.dispatched_line = r_hold_line;
                        n_res.dropped         = 1'b0;
                        n_res.last            = 1'b0;
                    end
                    n_have_hold = 1'b1;
                    n_hold_line = pick_line;
                    n_nres      = r_nres + NW'(1);
                    n_idx       = CW'(pick_pos) + CW'(1);
                    n_state     = S_REMOVE;
                end else begin
                    // nothing eligible: close the transaction
                    n_strobe              = 1'b1;
                    n_res.dispatched      = r_have_hold;
                    n_res.dispatched_line = r_have_hold ? r_hold_line : '0;
                    n_res.dropped         = 1'b0;
                    n_res.last            = 1'b1;
                    n_have_hold           = 1'b0;
                    n_state               = S_IDLE;
                end
            end
            S_REMOVE: begin
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                    if (!r_all || (r_nres == NW'(RESULT_LIMIT))) begin
                        n_strobe              = 1'b1;
                        n_res.dispatched      = 1'b1;
                        n_res.dispatched_line = r_hold_line;
                        n_res.dropped         = 1'b0;
                        n_res.last            = 1'b1;
                        n_have_hold           = 1'b0;
                        n_state               = S_IDLE;
                    end else begin
                        n_idx     = '0;
                        pick_init = 1'b1;
                        n_state   = S_SCAN;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_all       <= 1'b0;
            r_nres      <= '0;
            r_have_hold <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_all       <= n_all;
            r_nres      <= n_nres;
            r_have_hold <= n_have_hold;
            r_rd_vld    <= issue;
            r_strobe    <= n_strobe;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_hold_line <= n_hold_line;
        r_rd_pos    <= r_idx;
        r_res       <= n_res;
    end

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_en  <= 1'b1;
            r_line_mask  <= '0;
            r_prio_table <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GLOBAL_EN: r_global_en  <= i_cfg_data[0];
                CFG_LINE_MASK: r_line_mask  <= i_cfg_data[MASK_W-1:0];
                CFG_PRIO_TAB:  r_prio_table <= i_cfg_data[PTAB_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_res;

    `CHK_ALWAYS(a_count_in_range, r_count <= CW'(QUEUE_DEPTH), "fill count beyond queue depth")
    `CHK_ALWAYS(a_result_limit, r_nres <= NW'(RESULT_LIMIT), "too many results for one transaction")
    `CHK_NEXT(a_short_result, accept && (i_item.action == ACT_CLEAR || i_item.action == ACT_RAISE), o_result_strobe && o_result.last, "clear or raise gave no final result")
    `CHK_SAME(a_last_ends_busy, o_result_strobe && o_result.last, !busy, "busy after the final result")
    `CHK_SAME(a_more_keeps_busy, o_result_strobe && !o_result.last, busy, "idle before the final result")

endmodule

// ===== dv/tb_priority_interrupt_pending_queue.sv =====
// Self-checking testbench of the priority interrupt pending queue, with its own predictor.
module tb_priority_interrupt_pending_queue
    import pipq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Register index past the end of the register list: writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // Only the low PRIORITY_BITS of each priority nibble take part in the compare.
    localparam logic [3:0] PRIO_KEEP = 4'((1 << PRIORITY_BITS_DEF) - 1);
    // Bound on the wait for outstanding results.
    localparam int DRAIN_GUARD = 20000;
    // Quiet cycles at the end, enough to catch any stray result after the last one.
    localparam int SETTLE_CYCLES = 40;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_item                i_item;
    logic                 o_result_strobe;
    t_result              o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    // Predictor copy of the configuration, at its reset values.
    logic                 reg_gen  = 1'b1;
    logic [MASK_W-1:0]    reg_mask = '0;
    logic [PTAB_W-1:0]    reg_prio = '0;

    // Predicted queue contents, oldest first, and results still to arrive, oldest first.
    logic [LINE_W-1:0]    queued_lines[$];
    t_result              awaited_results[$];

    int                   mismatch_count = 0;
    int                   send_idle_pct  = 0;

    always #1 i_clk = ~i_clk;

    priority_interrupt_pending_queue i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Print one line per mismatch and count it.
    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Append one result to the tail of the awaited list.
    function automatic void expect_result(t_result r);
        awaited_results.insert(awaited_results.size(), r);
    endfunction

    // Mirror one register write into the predictor; unknown indexes change nothing.
    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
        case (idx)
            CFG_GLOBAL_EN: reg_gen  = d[0];
            CFG_LINE_MASK: reg_mask = d[MASK_W-1:0];
            CFG_PRIO_TAB:  reg_prio = d;
            default: ;
        endcase
    endfunction

    // Find the queue position to dispatch next: lowest priority value among eligible
    // entries, earliest arrival on a tie. Return -1 when nothing is eligible.
    function automatic int select_entry();
        int         best;
        logic [3:0] best_p;
        logic [3:0] p;
        best   = -1;
        best_p = '0;
        if (!reg_gen) begin
            return -1;
        end
        foreach (queued_lines[i]) begin
            if (reg_mask[queued_lines[i]]) begin
                p = reg_prio[int'(queued_lines[i]) * 4 +: 4] & PRIO_KEEP;
                // Strict less-than keeps the earlier entry on equal priority.
                if (best < 0 || p < best_p) begin
                    best   = i;
                    best_p = p;
                end
            end
        end
        return best;
    endfunction

    // Advance the predicted queue by one accepted transaction and queue up the results
    // it must produce, in the order the block emits them.
    function automatic void apply_action(t_item it);
        t_result r;
        int      pos;
        int      n;
        r      = '0;
        r.last = 1'b1;
        case (it.action)
            ACT_CLEAR: begin
                queued_lines.delete();
                expect_result(r);
            end
            ACT_RAISE: begin
                // Drop and flag a raise that finds the queue full.
                if (queued_lines.size() >= QUEUE_DEPTH_DEF) begin
                    r.dropped = 1'b1;
                end else begin
                    queued_lines.insert(queued_lines.size(), it.irq);
                end
                expect_result(r);
            end
            ACT_DISP_ONE: begin
                pos = select_entry();
                if (pos >= 0) begin
                    r.dispatched      = 1'b1;
                    r.dispatched_line = queued_lines[pos];
                    queued_lines.delete(pos);
                end
                expect_result(r);
            end
            default: begin
                // Dispatch-all: one result per removed entry, last on the final one.
                n = 0;
                while (n < RESULT_LIMIT) begin
                    pos = select_entry();
                    if (pos < 0) begin
                        break;
                    end
                    r.dispatched      = 1'b1;
                    r.dispatched_line = queued_lines[pos];
                    r.last            = 1'b0;
                    queued_lines.delete(pos);
                    expect_result(r);
                    n++;
                end
                if (n == 0) begin
                    expect_result(r);
                end else begin
                    awaited_results[awaited_results.size() - 1].last = 1'b1;
                end
            end
        endcase
    endfunction

    // Offer one transaction and hold it until the block takes it, optionally idling the
    // sender first. Start is left high on return, so the caller either sends again at
    // once or drops start through drain_results.
    task automatic send_item(t_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        apply_action(it);
    endtask

    // Drop start and wait until every awaited result has come back, with a bound.
    task automatic drain_results();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (awaited_results.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // Write all three registers in back-to-back transactions, optionally preceded by a
    // write to the spare index. Call only with the block idle, once per idle window.
    task automatic write_config(logic ge, logic [MASK_W-1:0] mask, logic [PTAB_W-1:0] ptab,
                                bit spare);
        logic [CFG_IDX_W-1:0] idx_l[4];
        logic [CFG_DAT_W-1:0] dat_l[4];
        int                   n;
        n = 0;
        if (spare) begin
            idx_l[n] = CFG_SPARE;
            dat_l[n] = {$urandom, $urandom};
            n++;
        end
        // Fill the unused upper bits with noise: the block must ignore them.
        idx_l[n]    = CFG_GLOBAL_EN;
        dat_l[n]    = {$urandom, $urandom};
        dat_l[n][0] = ge;
        n++;
        idx_l[n]           = CFG_LINE_MASK;
        dat_l[n]           = {$urandom, $urandom};
        dat_l[n][MASK_W-1:0] = mask;
        n++;
        idx_l[n] = CFG_PRIO_TAB;
        dat_l[n] = ptab;
        n++;
        for (int k = 0; k < n; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_l[k];
            i_cfg_data  <= dat_l[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            apply_register(idx_l[k], dat_l[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_item make_item(logic [ACTION_W-1:0] act, logic [LINE_W-1:0] line);
        t_item it;
        it.action = act;
        it.irq    = line;
        return it;
    endfunction

    // Dispatches on an empty queue, raises of both extreme lines, and dispatches that
    // find nothing eligible: mask at reset (all lines off), then global enable off.
    task automatic test_empty_queue();
        send_item(make_item(ACT_DISP_ONE, 4'd0));
        send_item(make_item(ACT_DISP_ALL, 4'd0));
        send_item(make_item(ACT_RAISE, 4'd0));
        send_item(make_item(ACT_RAISE, 4'd15));
        send_item(make_item(ACT_DISP_ONE, 4'd0));
        drain_results();
        write_config(1'b0, 16'hFFFF, 64'h0, 1'b1);
        send_item(make_item(ACT_DISP_ALL, 4'd0));
    endtask

    // Fill the queue to the brim, with a duplicate line, then overflow it by one.
    task automatic test_full_queue();
        drain_results();
        // Line n gets priority 15 - n, so line 15 wins and line 0 loses.
        write_config(1'b1, 16'hFFFF, 64'h0123_4567_89AB_CDEF, 1'b0);
        for (int i = 1; i <= 14; i++) begin
            send_item(make_item(ACT_RAISE, 4'((i * 5) % 16)));
        end
        send_item(make_item(ACT_RAISE, 4'd11));
    endtask

    // Pick by priority, then empty the enabled lines with all priorities tied so that
    // arrival order alone decides; masked lines stay queued.
    task automatic test_dispatch_order();
        send_item(make_item(ACT_DISP_ONE, 4'd0));
        drain_results();
        write_config(1'b1, 16'h5A5A, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(make_item(ACT_DISP_ALL, 4'd0));
    endtask

    // Clear a non-empty queue, confirm it is empty, then reuse it.
    task automatic test_clear();
        send_item(make_item(ACT_CLEAR, 4'd0));
        send_item(make_item(ACT_DISP_ONE, 4'd0));
        send_item(make_item(ACT_RAISE, 4'd3));
        send_item(make_item(ACT_DISP_ALL, 4'd0));
    endtask

    // Random traffic under changing configurations. Raises outnumber dispatches so
    // the queue often fills and drops; clears keep it from staying full.
    task automatic test_random_traffic(int n_items, int idle_pct);
        t_item             it;
        int                sel;
        logic              ge;
        logic [MASK_W-1:0] mask;
        logic [PTAB_W-1:0] ptab;
        send_idle_pct = idle_pct;
        for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 0) begin
                drain_results();
                ge = ($urandom_range(9) != 0);
                case ($urandom_range(7))
                    0:       mask = '0;
                    1, 2:    mask = 16'hFFFF;
                    default: mask = 16'($urandom);
                endcase
                case ($urandom_range(5))
                    0: ptab = '0;
                    1: ptab = '1;
                    2: begin
                        // Few distinct values: plenty of ties.
                        ptab = {$urandom, $urandom} & 64'h3333_3333_3333_3333;
                    end
                    default: ptab = {$urandom, $urandom};
                endcase
                write_config(ge, mask, ptab, $urandom_range(3) == 0);
            end
            sel = $urandom_range(99);
            if (sel < 52) begin
                it.action = ACT_RAISE;
            end else if (sel < 78) begin
                it.action = ACT_DISP_ONE;
            end else if (sel < 93) begin
                it.action = ACT_DISP_ALL;
            end else begin
                it.action = ACT_CLEAR;
            end
            // Randomise the line even where the action ignores it.
            it.irq = 4'($urandom_range(15));
            send_item(it);
        end
    endtask

    // Check every result transaction against the oldest awaited one, field by field.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_result_strobe) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", o_result));
            end else begin
                want = awaited_results.pop_front();
                if (o_result.dispatched !== want.dispatched) begin
                    report_mismatch($sformatf("dispatched got %b want %b",
                                              o_result.dispatched, want.dispatched));
                end
                if (o_result.dispatched_line !== want.dispatched_line) begin
                    report_mismatch($sformatf("dispatched_line got %0d want %0d",
                                              o_result.dispatched_line, want.dispatched_line));
                end
                if (o_result.dropped !== want.dropped) begin
                    report_mismatch($sformatf("dropped got %b want %b",
                                              o_result.dropped, want.dropped));
                end
                if (o_result.last !== want.last) begin
                    report_mismatch($sformatf("last got %b want %b",
                                              o_result.last, want.last));
                end
            end
        end
    end

    initial begin
        // Hold every input at a known value and keep the block in reset.
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 11;
        test_empty_queue();
        test_full_queue();
        test_dispatch_order();
        test_clear();

        // Sender idles seldom, then often, then never.
        test_random_traffic(131, 11);
        test_random_traffic(131, 88);
        test_random_traffic(131, 0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        end

        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
